// ===== rtl/rba_pkg.sv =====
`default_nettype none

package rba_pkg;

  // offsets and stored block lengths are kept to OFS_W bits, request lengths to LEN_W
  localparam int unsigned OFS_W = 13;
  localparam int unsigned LEN_W = 12;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned STAT_W = 2;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_SPILLED   = 2'd1,
    ST_IGNORED   = 2'd2,
    ST_OUT_ORDER = 2'd3
  } status_e;

endpackage

`default_nettype wire

// ===== rtl/rba_ram.sv =====
`default_nettype none

module rba_ram #(
  parameter int unsigned WIDTH = 13,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ring_block_allocator_top.sv =====
`default_nettype none

// allocate: result strobe in the cycle after the accepting edge, one allocate per cycle while busy is low
// free: the result follows the length memory read in S_READ and is then registered,
//   busy is high during that read, so no new request is taken until it is done
// frees that are ignored or out of order answer in the next cycle without a read
// reset: pointers and counters to zero, ring_size to 4096; length memory not cleared
// results are shown for one cycle on done_o and the receiver cannot stall them
module ring_block_allocator_top
  import rba_pkg::*;
#(
  parameter int unsigned RING_BYTES   = 4096,
  parameter int unsigned HEADER_BYTES = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // command channel
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              operation_i,
  input  wire logic [LEN_W-1:0]  payload_length_i,
  input  wire logic [OFS_W-1:0]  payload_offset_i,
  input  wire logic              outside_ring_i,
  // configuration
  input  wire logic              cfg_we_i,
  input  wire logic [OFS_W-1:0]  cfg_wdata_i,
  // result channel
  output logic                   done_o,
  output logic [STAT_W-1:0]      status_o,
  output logic [OFS_W-1:0]       result_offset_o,
  output logic [CNT_W-1:0]       alloc_total_o,
  output logic [CNT_W-1:0]       spill_total_o
);

  localparam int unsigned AW = $clog2(RING_BYTES);
  localparam logic [OFS_W-1:0] HDR = OFS_W'(HEADER_BYTES);

  // controller states
  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic             state_q, state_d;
  logic [OFS_W-1:0] ring_size_q;
  logic [OFS_W-1:0] start_q, start_d;
  logic [OFS_W-1:0] end_q, end_d;
  logic [CNT_W-1:0] alloc_cnt_q, alloc_cnt_d;
  logic [CNT_W-1:0] spill_cnt_q, spill_cnt_d;
  logic             done_q, done_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic [OFS_W-1:0] result_q, result_d;
  // context of the free whose length read is in flight
  logic             from_start_q, from_start_d;
  logic             in_range_q, in_range_d;

  logic             accept;
  logic [OFS_W-1:0] eff_size;
  logic [OFS_W:0]   size_x;

  // allocate path
  logic [OFS_W-1:0] blk_len;
  logic [OFS_W:0]   end_sum;
  logic             placed;
  logic [OFS_W-1:0] at;
  logic [OFS_W-1:0] alloc_end;

  // free path
  logic [OFS_W-1:0] blk;
  logic             free_ignore;
  logic             hit_start;
  logic             hit_zero;

  // memory side
  logic             ram_we;
  logic             ram_re;
  logic [OFS_W-1:0] ram_rdata;
  logic [OFS_W-1:0] rd_len;
  logic [OFS_W:0]   start_sum;

  assign busy   = (state_q == S_READ);
  assign accept = start && !busy;

  // a ring_size above the memory depth acts as the depth
  assign eff_size = (32'(ring_size_q) > 32'(RING_BYTES)) ? OFS_W'(RING_BYTES) : ring_size_q;
  assign size_x   = {1'b0, eff_size};

  // placement: behind end, else wrap to offset zero, else spill
  assign blk_len = OFS_W'(payload_length_i) + HDR;
  assign end_sum = {1'b0, end_q} + {1'b0, blk_len};

  always_comb begin
    placed    = 1'b0;
    at        = '0;
    alloc_end = end_q;
    if (start_q > end_q) begin
      if (end_sum < {1'b0, start_q}) begin
        placed    = 1'b1;
        at        = end_q;
        alloc_end = end_sum[OFS_W-1:0];
      end
    end else if ((end_sum > size_x) || ((end_sum == size_x) && (start_q == '0))) begin
      // no room up to the ring end, try the front
      if (blk_len < start_q) begin
        placed    = 1'b1;
        at        = '0;
        alloc_end = blk_len;
      end
    end else begin
      placed    = 1'b1;
      at        = end_q;
      // exact fit to the ring end wraps end to zero
      alloc_end = (end_sum == size_x) ? '0 : end_sum[OFS_W-1:0];
    end
  end

  // free classification
  assign blk         = payload_offset_i - HDR;
  assign free_ignore = outside_ring_i || (payload_offset_i < HDR) || (blk > eff_size);
  assign hit_start   = (blk == start_q);
  assign hit_zero    = (blk == '0);

  // length memory: written by allocate, read by free
  assign ram_we = accept && (operation_i == OP_ALLOC) && placed
                  && (32'(at) < 32'(RING_BYTES));
  assign ram_re = accept && (operation_i == OP_FREE) && !free_ignore
                  && (hit_start || hit_zero);

  rba_ram #(
    .WIDTH (OFS_W),
    .DEPTH (RING_BYTES)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(at)),
    .wdata_i (blk_len),
    .re_i    (ram_re),
    .raddr_i (AW'(blk)),
    .rdata_o (ram_rdata)
  );

  // lengths beyond the memory read as zero
  assign rd_len    = in_range_q ? ram_rdata : '0;
  assign start_sum = {1'b0, start_q} + {1'b0, rd_len};

  always_comb begin
    state_d      = state_q;
    start_d      = start_q;
    end_d        = end_q;
    alloc_cnt_d  = alloc_cnt_q;
    spill_cnt_d  = spill_cnt_q;
    done_d       = 1'b0;
    status_d     = status_q;
    result_d     = result_q;
    from_start_d = from_start_q;
    in_range_d   = in_range_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (operation_i == OP_ALLOC) begin
            // every allocate counts, spilled or not
            alloc_cnt_d = alloc_cnt_q + CNT_W'(1);
            done_d      = 1'b1;
            if (placed) begin
              end_d    = alloc_end;
              status_d = ST_OK;
              result_d = at + HDR;
            end else begin
              spill_cnt_d = spill_cnt_q + CNT_W'(1);
              status_d    = ST_SPILLED;
              result_d    = '0;
            end
          end else begin
            result_d = '0;
            if (free_ignore) begin
              done_d   = 1'b1;
              status_d = ST_IGNORED;
            end else if (hit_start || hit_zero) begin
              // fetch the stored block length, answer from S_READ
              state_d      = S_READ;
              from_start_d = hit_start;
              in_range_d   = (32'(blk) < 32'(RING_BYTES));
            end else begin
              done_d   = 1'b1;
              status_d = ST_OUT_ORDER;
            end
          end
        end
      end
      S_READ: begin
        state_d  = S_IDLE;
        done_d   = 1'b1;
        status_d = ST_OK;
        if (from_start_q) begin
          // oldest block released, wrap at the ring end
          start_d = (start_sum == size_x) ? '0 : start_sum[OFS_W-1:0];
        end else begin
          // block at the front: start moves past it
          start_d = rd_len;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ring_size_q  <= OFS_W'(4096);
      start_q      <= '0;
      end_q        <= '0;
      alloc_cnt_q  <= '0;
      spill_cnt_q  <= '0;
      done_q       <= 1'b0;
      from_start_q <= 1'b0;
      in_range_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      start_q      <= start_d;
      end_q        <= end_d;
      alloc_cnt_q  <= alloc_cnt_d;
      spill_cnt_q  <= spill_cnt_d;
      done_q       <= done_d;
      from_start_q <= from_start_d;
      in_range_q   <= in_range_d;
      if (cfg_we_i) begin
        ring_size_q <= cfg_wdata_i;
      end
    end
  end

  // result payload, valid while done_o is high
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    result_q <= result_d;
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign result_offset_o = result_q;
  // counters only move on an allocate transaction, so they match the result shown
  assign alloc_total_o   = alloc_cnt_q;
  assign spill_total_o   = spill_cnt_q;

endmodule

`default_nettype wire

// ===== sim/ring_block_allocator_top_test.sv =====
`default_nettype none

// ring block allocator test: a short directed table, then random allocate/free
// traffic in several ring size phases, every result checked against a local
// copy of the ring state (start/end offsets, stored block lengths, counters)
module ring_block_allocator_top_test;
  import rba_pkg::*;

  localparam int unsigned RING_BYTES  = 4096;
  localparam int unsigned HDR_BYTES   = 8;
  localparam int unsigned STALL_LIMIT = 500;
  localparam int unsigned NUM_PHASES  = 6;

  // one result transaction as it should appear on the result ports
  typedef struct packed {
    status_e           status;
    logic [OFS_W-1:0]  offset;
    logic [CNT_W-1:0]  alloc_total;
    logic [CNT_W-1:0]  spill_total;
  } ring_reply_t;

  // one row of the directed table; typed marks rows whose status and offset
  // are written out by hand instead of taken from the ring state copy
  typedef struct packed {
    op_e               op;
    logic [LEN_W-1:0]  plen;
    logic [OFS_W-1:0]  pofs;
    logic              outside;
    logic              typed;
    status_e           st;
    logic [OFS_W-1:0]  ofs;
  } plan_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic              operation_i;
  logic [LEN_W-1:0]  payload_length_i;
  logic [OFS_W-1:0]  payload_offset_i;
  logic              outside_ring_i;
  logic              cfg_we_i;
  logic [OFS_W-1:0]  cfg_wdata_i;
  logic              done_o;
  logic [STAT_W-1:0] status_o;
  logic [OFS_W-1:0]  result_offset_o;
  logic [CNT_W-1:0]  alloc_total_o;
  logic [CNT_W-1:0]  spill_total_o;

  // local copy of the allocator state
  logic [OFS_W-1:0]  ring_sz;
  logic [OFS_W-1:0]  head_ofs;
  logic [OFS_W-1:0]  tail_ofs;
  logic [OFS_W-1:0]  blk_len [RING_BYTES];
  bit                len_known [RING_BYTES];
  logic [CNT_W-1:0]  alloc_cnt;
  logic [CNT_W-1:0]  spill_cnt;

  ring_reply_t       reply_q [$];   // results still owed by the block, oldest first
  logic [OFS_W-1:0]  live_q [$];    // payload offsets of blocks in the ring, alloc order
  ring_reply_t       want;
  int unsigned       err_cnt = 0;

  ring_block_allocator_top #(
    .RING_BYTES   (RING_BYTES),
    .HEADER_BYTES (HDR_BYTES)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .operation_i      (operation_i),
    .payload_length_i (payload_length_i),
    .payload_offset_i (payload_offset_i),
    .outside_ring_i   (outside_ring_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .result_offset_o  (result_offset_o),
    .alloc_total_o    (alloc_total_o),
    .spill_total_o    (spill_total_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ring size in effect: anything above the ring capacity acts as the capacity
  function automatic int unsigned ring_limit();
    return (ring_sz > RING_BYTES) ? RING_BYTES : int'(ring_sz);
  endfunction

  // apply one request to the state copy and return the result it must give
  function automatic ring_reply_t ring_outcome(input op_e op, input logic [LEN_W-1:0] plen,
                                               input logic [OFS_W-1:0] pofs,
                                               input logic outside);
    int unsigned lim, blen, at, blk, nxt;
    bit          placed;
    ring_reply_t r;
    lim = ring_limit();
    r.status = ST_OK;
    r.offset = '0;
    if (op == OP_ALLOC) begin
      blen   = int'(plen) + HDR_BYTES;
      placed = 1'b0;
      at     = 0;
      if (head_ofs > tail_ofs) begin
        // wrapped: only the gap between end and start is usable
        if (tail_ofs + blen < head_ofs) begin
          at       = tail_ofs;
          placed   = 1'b1;
          tail_ofs = OFS_W'(tail_ofs + blen);
        end
      end else if (tail_ofs + blen > lim || (tail_ofs + blen == lim && head_ofs == 0)) begin
        // no room at the end, try the front of the ring
        if (blen < head_ofs) begin
          at       = 0;
          placed   = 1'b1;
          tail_ofs = OFS_W'(blen);
        end
      end else begin
        at       = tail_ofs;
        placed   = 1'b1;
        tail_ofs = (tail_ofs + blen == lim) ? '0 : OFS_W'(tail_ofs + blen);
      end
      alloc_cnt++;
      if (placed) begin
        if (at < RING_BYTES) begin
          blk_len[at]   = OFS_W'(blen);
          len_known[at] = 1'b1;
        end
        r.offset = OFS_W'(at + HDR_BYTES);
      end else begin
        spill_cnt++;
        r.status = ST_SPILLED;
      end
    end else begin
      if (outside || pofs < HDR_BYTES || int'(pofs) - HDR_BYTES > lim) begin
        r.status = ST_IGNORED;
      end else begin
        blk = int'(pofs) - HDR_BYTES;
        if (blk == head_ofs) begin
          // oldest block: advance start, wrapping at the ring size
          nxt = head_ofs + ((blk < RING_BYTES) ? int'(blk_len[blk]) : 0);
          if (nxt == lim) nxt = 0;
          head_ofs = OFS_W'(nxt);
        end else if (blk == 0) begin
          // block that wrapped to the front: start jumps past it
          head_ofs = blk_len[0];
        end else begin
          r.status = ST_OUT_ORDER;
        end
      end
    end
    r.alloc_total = alloc_cnt;
    r.spill_total = spill_cnt;
    return r;
  endfunction

  // drive one request, wait for the transaction, queue its result
  task automatic issue(input op_e op, input logic [LEN_W-1:0] plen,
                       input logic [OFS_W-1:0] pofs, input logic outside,
                       input logic typed, input status_e t_st,
                       input logic [OFS_W-1:0] t_ofs, output status_e got);
    ring_reply_t r;
    bit          found;
    @(negedge clk_i);
    start            <= 1'b1;
    operation_i      <= op;
    payload_length_i <= plen;
    payload_offset_i <= pofs;
    outside_ring_i   <= outside;
    do @(posedge clk_i); while (busy);
    r   = ring_outcome(op, plen, pofs, outside);
    got = r.status;
    // keep the list of blocks in the ring in step with the state copy
    if (op == OP_ALLOC && r.status == ST_OK) begin
      live_q.push_back(r.offset);
    end else if (op == OP_FREE && r.status == ST_OK) begin
      found = 1'b0;
      for (int i = 0; i < live_q.size() && !found; i++) begin
        if (live_q[i] == pofs) begin
          live_q.delete(i);
          found = 1'b1;
        end
      end
    end
    if (typed) begin
      r.status = t_st;
      r.offset = t_ofs;
    end
    reply_q.push_back(r);
  endtask

  // sender gap with start low, its length set by n
  task automatic pause(input int unsigned n);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // ring size is only changed once the block has nothing in flight
  task automatic set_ring_size(input logic [OFS_W-1:0] sz);
    @(negedge clk_i);
    start <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= sz;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    ring_sz  = sz;
  endtask

  // result checker: every strobe must match the oldest owed result
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (reply_q.size() == 0) begin
        $display("%0t: result with none owed: status %0d offset %0d", $time, status_o,
                 result_offset_o);
        err_cnt++;
      end else begin
        want = reply_q.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, status_o);
          err_cnt++;
        end
        if (result_offset_o !== want.offset) begin
          $display("%0t: result_offset expected %0d got %0d", $time, want.offset,
                   result_offset_o);
          err_cnt++;
        end
        if (alloc_total_o !== want.alloc_total) begin
          $display("%0t: alloc_total expected %0d got %0d", $time, want.alloc_total,
                   alloc_total_o);
          err_cnt++;
        end
        if (spill_total_o !== want.spill_total) begin
          $display("%0t: spill_total expected %0d got %0d", $time, want.spill_total,
                   spill_total_o);
          err_cnt++;
        end
      end
    end
  end

  // watchdog: too long without any transaction on either side ends the run
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((start && !busy) || done_o) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    plan_row_t         plan [18];
    logic [OFS_W-1:0]  phase_size [NUM_PHASES];
    int unsigned       phase_idle [NUM_PHASES];
    int unsigned       phase_items [NUM_PHASES];
    status_e           got;
    op_e               op;
    logic [LEN_W-1:0]  plen;
    logic [OFS_W-1:0]  pofs;
    logic              outside;
    int unsigned       lim, cap, sel, blk, left, drain_n;

    // all inputs known from time zero, reset held low at the start
    rst_ni           = 1'b0;
    start            = 1'b0;
    operation_i      = OP_ALLOC;
    payload_length_i = '0;
    payload_offset_i = '0;
    outside_ring_i   = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;

    ring_sz   = 13'd4096;
    head_ofs  = '0;
    tail_ofs  = '0;
    alloc_cnt = '0;
    spill_cnt = '0;
    foreach (len_known[i]) len_known[i] = 1'b0;

    // directed table, ring size at its reset value of 4096
    plan = '{
      // first block lands at offset 0
      '{OP_ALLOC, 12'd0,    13'd0,    1'b0, 1'b1, ST_OK,        13'd8},
      // largest request never fits next to a live block
      '{OP_ALLOC, 12'd4095, 13'd0,    1'b0, 1'b1, ST_SPILLED,   13'd0},
      '{OP_FREE,  12'd0,    13'd8,    1'b0, 1'b0, ST_OK,        13'd0},
      // spilled or null block
      '{OP_FREE,  12'd0,    13'd8,    1'b1, 1'b1, ST_IGNORED,   13'd0},
      // offset below the header
      '{OP_FREE,  12'd0,    13'd0,    1'b0, 1'b1, ST_IGNORED,   13'd0},
      // offset near the top of the ring, neither start nor front
      '{OP_FREE,  12'd4095, 13'd4103, 1'b0, 1'b1, ST_OUT_ORDER, 13'd0},
      // block ends exactly at the ring size, end wraps to 0
      '{OP_ALLOC, 12'd4080, 13'd0,    1'b0, 1'b0, ST_OK,        13'd0},
      '{OP_ALLOC, 12'd0,    13'd0,    1'b0, 1'b0, ST_OK,        13'd0},
      // start reaches the ring size and wraps
      '{OP_FREE,  12'd0,    13'd16,   1'b0, 1'b0, ST_OK,        13'd0},
      // whole ring with start at 0 does not fit
      '{OP_ALLOC, 12'd4088, 13'd0,    1'b0, 1'b0, ST_OK,        13'd0},
      '{OP_ALLOC, 12'd4087, 13'd0,    1'b0, 1'b0, ST_OK,        13'd0},
      '{OP_ALLOC, 12'd0,    13'd0,    1'b0, 1'b0, ST_OK,        13'd0},
      '{OP_FREE,  12'd0,    13'd8,    1'b0, 1'b0, ST_OK,        13'd0},
      // no room at the end, block wraps to the front
      '{OP_ALLOC, 12'd100,  13'd0,    1'b0, 1'b0, ST_OK,        13'd0},
      '{OP_ALLOC, 12'd0,    13'd0,    1'b0, 1'b0, ST_OK,        13'd0},
      // free of the front block while start is elsewhere
      '{OP_FREE,  12'd0,    13'd8,    1'b0, 1'b0, ST_OK,        13'd0},
      '{OP_FREE,  12'd0,    13'd116,  1'b0, 1'b0, ST_OK,        13'd0},
      // free-only fields set on an allocate
      '{OP_ALLOC, 12'd0,    13'd4103, 1'b1, 1'b0, ST_OK,        13'd0}
    };

    // ring size, sender idle percentage and item count of each random phase
    phase_size  = '{13'd4096, 13'd16, 13'd8191, 13'd0, 13'd300,
                    OFS_W'($urandom_range(16, 4096))};
    phase_idle  = '{0, 45, 24, 0, 45, 24};
    phase_items = '{200, 150, 200, 60, 200, 220};

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      issue(plan[i].op, plan[i].plen, plan[i].pofs, plan[i].outside, plan[i].typed,
            plan[i].st, plan[i].ofs, got);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      // empty the ring in order so the new size starts from a clean layout
      drain_n = live_q.size();
      repeat (drain_n) begin
        pofs = live_q[0];
        issue(OP_FREE, LEN_W'($urandom), pofs, 1'b0, 1'b0, ST_OK, '0, got);
        if (live_q.size() != 0 && live_q[0] == pofs) void'(live_q.pop_front());
      end
      set_ring_size(phase_size[p]);

      left = phase_items[p];
      while (left > 0) begin
        lim     = ring_limit();
        sel     = $urandom_range(0, 99);
        plen    = LEN_W'($urandom);
        pofs    = OFS_W'($urandom_range(0, 4103));
        outside = 1'(($urandom_range(0, 3) == 0));
        if (sel < 55 || (live_q.size() == 0 && sel < 85)) begin
          // allocate, mostly sizes that fit the current ring
          op  = OP_ALLOC;
          cap = (lim < 64) ? 7 : lim / 8;
          case ($urandom_range(0, 9))
            7, 8:    plen = LEN_W'($urandom_range(0, 1023));
            9:       plen = LEN_W'($urandom_range(0, 4095));
            default: plen = LEN_W'($urandom_range(0, cap));
          endcase
        end else if (sel < 85) begin
          // well-formed free of the oldest block
          op      = OP_FREE;
          pofs    = live_q[0];
          outside = 1'b0;
        end else begin
          // broken frees: random, below the header, out of order, or flagged null
          op = OP_FREE;
          case ($urandom_range(0, 3))
            0: ;
            1: pofs = OFS_W'($urandom_range(0, HDR_BYTES - 1));
            2: if (live_q.size() != 0)
                 pofs = live_q[$urandom_range(0, live_q.size() - 1)];
            default: begin
              if (live_q.size() != 0) pofs = live_q[0];
              outside = 1'b1;
            end
          endcase
        end
        // never look up the length of a block offset that was never written
        if (op == OP_FREE && !outside && pofs >= HDR_BYTES &&
            int'(pofs) - HDR_BYTES <= lim) begin
          blk = int'(pofs) - HDR_BYTES;
          if ((blk == head_ofs || blk == 0) && blk < RING_BYTES && !len_known[blk])
            outside = 1'b1;
        end
        issue(op, plen, pofs, outside, 1'b0, ST_OK, '0, got);
        left--;
        if ($urandom_range(0, 99) < phase_idle[p]) pause($urandom_range(1, 3));
      end
    end

    // let the last results come out, then check for results that never arrived
    @(negedge clk_i);
    start <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (reply_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, reply_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
